FILE: hdl/thfp_pkg.sv
// ----------------------------------------------------------------------------
// Track heading package
// Shared widths, the queued job record, the back-end state encoding and the
// arctangent table of the vectoring CORDIC.
// ----------------------------------------------------------------------------
package thfp_pkg;

	localparam int COORD_BITS_DEF   = 32;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int EAST_W      = 32;
	localparam int NORTH_W     = 31;
	localparam int HEAD_W      = 16;
	localparam int ACC_W       = 32;
	localparam int DE_W        = EAST_W + 1;
	localparam int DN_W        = NORTH_W + 1;
	localparam int ATAN_IDX_W  = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 80;

	localparam logic [ACC_W-1:0] HALF_TURN  = 32'h8000_0000;
	localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;

	// One unit of work for the back end. A job without seg is a lone point.
	typedef struct packed {
		logic                       seg;
		logic                       last;
		logic signed [EAST_W-1:0]   prev_east;
		logic signed [NORTH_W-1:0]  prev_north;
		logic signed [EAST_W-1:0]   cur_east;
		logic signed [NORTH_W-1:0]  cur_north;
		logic signed [DE_W-1:0]     delta_east;
		logic signed [DN_W-1:0]     delta_north;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_ITER,
		BK_EMIT_SEG,
		BK_EMIT_END
	} back_state_t;

	// atan(2^-i) in units of 2^-32 turn.
	function automatic logic [ACC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [ACC_W-1:0] r;
		case (idx)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10679838;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			5'd20:   r = 32'd652;
			5'd21:   r = 32'd326;
			5'd22:   r = 32'd163;
			5'd23:   r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/thfp_front.sv
// ----------------------------------------------------------------------------
// Track heading front end
// Accepts points, holds the previous one and turns points into jobs.
// ----------------------------------------------------------------------------
module thfp_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [thfp_pkg::EAST_W-1:0]    in_east,
	input  logic signed [thfp_pkg::NORTH_W-1:0]   in_north,
	input  logic                                  in_last,
	input  logic                                  q_full,
	output logic                                  push,
	output thfp_pkg::job_t                        job
);

	logic                                 accept;
	logic                                 have_prev_q;
	logic signed [thfp_pkg::EAST_W-1:0]   prev_east_q;
	logic signed [thfp_pkg::NORTH_W-1:0]  prev_north_q;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	// A first point that is not last is only stored; all else makes a job.
	assign push     = accept && (have_prev_q || in_last);

	always_comb begin
		job             = '0;
		job.seg         = have_prev_q;
		job.last        = in_last;
		job.prev_east   = prev_east_q;
		job.prev_north  = prev_north_q;
		job.cur_east    = in_east;
		job.cur_north   = in_north;
		job.delta_east  = thfp_pkg::DE_W'(in_east) - thfp_pkg::DE_W'(prev_east_q);
		job.delta_north = thfp_pkg::DN_W'(in_north) - thfp_pkg::DN_W'(prev_north_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_east_q  <= '0;
			prev_north_q <= '0;
		end else if (accept) begin
			prev_east_q  <= in_east;
			prev_north_q <= in_north;
			have_prev_q  <= !in_last;
		end
	end

endmodule

FILE: hdl/thfp_queue.sv
// ----------------------------------------------------------------------------
// Track heading job queue
// Short first-in first-out buffer of jobs between front and back end.
// ----------------------------------------------------------------------------
module thfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  thfp_pkg::job_t  push_job,
	input  logic            pop,
	output thfp_pkg::job_t  head,
	output logic            empty,
	output logic            full
);

	localparam int PW = (thfp_pkg::QUEUE_DEPTH > 1) ? $clog2(thfp_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(thfp_pkg::QUEUE_DEPTH + 1);

	thfp_pkg::job_t  mem_q [thfp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(thfp_pkg::QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/thfp_back.sv
// ----------------------------------------------------------------------------
// Track heading back end
// Iterative vectoring CORDIC, one step per cycle, and the result register.
// ----------------------------------------------------------------------------
module thfp_back #(
	parameter int COORD_BITS   = thfp_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STEPS = thfp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  thfp_pkg::job_t                      q_head,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [thfp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast
);

	localparam int CW     = COORD_BITS + 2;
	localparam int EW     = (CW > thfp_pkg::DE_W) ? CW : thfp_pkg::DE_W;
	localparam int MAXK   = (COORD_BITS >= thfp_pkg::DE_W) ? 0 : thfp_pkg::DE_W - COORD_BITS;
	localparam int KW     = (MAXK > 0) ? $clog2(MAXK + 1) : 1;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	thfp_pkg::back_state_t           state_q;
	thfp_pkg::back_state_t           state_d;
	thfp_pkg::job_t                  job_q;
	logic signed [CW-1:0]            x_q;
	logic signed [CW-1:0]            y_q;
	logic [thfp_pkg::ACC_W-1:0]      acc_q;
	logic [STEP_W-1:0]               step_q;

	logic                            out_free;
	logic                            load_out;
	logic                            out_end;
	logic                            head_zero;

	logic signed [EW-1:0]            de_w;
	logic signed [EW-1:0]            dn_w;
	logic signed [EW-1:0]            de_s;
	logic signed [EW-1:0]            dn_s;
	logic [KW-1:0]                   ksel;
	logic signed [CW-1:0]            x_pre;
	logic signed [CW-1:0]            y_pre;
	logic                            neg;

	logic signed [CW-1:0]            x_sh;
	logic signed [CW-1:0]            y_sh;
	logic                            rot_cw;
	logic [thfp_pkg::ACC_W-1:0]      atan_v;
	logic [thfp_pkg::ACC_W-1:0]      acc_rnd;

	logic                            m_tvalid_q;
	logic [thfp_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                            m_tlast_q;

	assign out_free  = !m_tvalid_q || m_tready;
	assign head_zero = (q_head.delta_east == '0) && (q_head.delta_north == '0);

	// Normalization: smallest right shift that brings both deltas into
	// COORD_BITS signed bits, then fold the left half plane onto the right.
	always_comb begin
		logic signed [EW-1:0] te;
		logic signed [EW-1:0] tn;
		de_w = EW'(job_q.delta_east);
		dn_w = EW'(job_q.delta_north);
		ksel = KW'(MAXK);
		for (int k = MAXK; k >= 0; k--) begin
			te = de_w >>> (COORD_BITS - 1 + k);
			tn = dn_w >>> (COORD_BITS - 1 + k);
			if ((te == '0 || te == '1) && (tn == '0 || tn == '1)) begin
				ksel = KW'(k);
			end
		end
		de_s  = de_w >>> ksel;
		dn_s  = dn_w >>> ksel;
		x_pre = signed'(dn_s[CW-1:0]);
		y_pre = signed'(de_s[CW-1:0]);
		neg   = x_pre[CW-1];
	end

	assign x_sh    = x_q >>> step_q;
	assign y_sh    = y_q >>> step_q;
	assign rot_cw  = !y_q[CW-1] && (y_q != '0);
	assign atan_v  = thfp_pkg::atan_turn(thfp_pkg::ATAN_IDX_W'(step_q));
	assign acc_rnd = acc_q + thfp_pkg::ROUND_HALF;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			thfp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (!q_head.seg) begin
						state_d = thfp_pkg::BK_EMIT_END;
					end else if (head_zero) begin
						state_d = thfp_pkg::BK_EMIT_SEG;
					end else begin
						state_d = thfp_pkg::BK_SETUP;
					end
				end
			end
			thfp_pkg::BK_SETUP: begin
				state_d = thfp_pkg::BK_ITER;
			end
			thfp_pkg::BK_ITER: begin
				if (step_q == LAST_STEP) begin
					state_d = thfp_pkg::BK_EMIT_SEG;
				end
			end
			thfp_pkg::BK_EMIT_SEG: begin
				if (out_free) begin
					state_d = job_q.last ? thfp_pkg::BK_EMIT_END : thfp_pkg::BK_IDLE;
				end
			end
			thfp_pkg::BK_EMIT_END: begin
				if (out_free) begin
					state_d = thfp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = thfp_pkg::BK_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		out_end  = 1'b0;
		case (state_q)
			thfp_pkg::BK_IDLE: begin
				pop = !q_empty;
			end
			thfp_pkg::BK_EMIT_SEG: begin
				load_out = out_free;
			end
			thfp_pkg::BK_EMIT_END: begin
				load_out = out_free;
				out_end  = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thfp_pkg::BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == thfp_pkg::BK_SETUP) begin
				step_q <= '0;
			end else if (state_q == thfp_pkg::BK_ITER) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			thfp_pkg::BK_IDLE: begin
				if (pop) begin
					job_q <= q_head;
					// Zero heading for lone points and zero-length segments.
					acc_q <= '0;
				end
			end
			thfp_pkg::BK_SETUP: begin
				x_q   <= neg ? -x_pre : x_pre;
				y_q   <= neg ? -y_pre : y_pre;
				acc_q <= neg ? thfp_pkg::HALF_TURN : '0;
			end
			thfp_pkg::BK_ITER: begin
				if (rot_cw) begin
					x_q   <= x_q + y_sh;
					y_q   <= y_q - x_sh;
					acc_q <= acc_q + atan_v;
				end else begin
					x_q   <= x_q - y_sh;
					y_q   <= y_q + x_sh;
					acc_q <= acc_q - atan_v;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tlast_q <= out_end;
			if (out_end) begin
				m_tdata_q <= {1'b0, acc_rnd[thfp_pkg::ACC_W-1 -: thfp_pkg::HEAD_W],
					job_q.cur_north, job_q.cur_east};
			end else begin
				m_tdata_q <= {1'b0, acc_rnd[thfp_pkg::ACC_W-1 -: thfp_pkg::HEAD_W],
					job_q.prev_north, job_q.prev_east};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_iter_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == thfp_pkg::BK_ITER && step_q == LAST_STEP) |=>
			(state_q == thfp_pkg::BK_EMIT_SEG))
		else $error("CORDIC did not hand over after its last step");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == thfp_pkg::BK_ITER) |-> (step_q <= LAST_STEP))
		else $error("CORDIC step counter out of range");

	a_x_folded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == thfp_pkg::BK_SETUP) |=> !x_q[CW-1])
		else $error("CORDIC start vector not in the right half plane");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && state_q == thfp_pkg::BK_EMIT_END) |=> (m_tvalid_q && m_tlast_q))
		else $error("final track result lost its end flag");

endmodule

FILE: hdl/track_heading_from_points.sv
// ----------------------------------------------------------------------------
// Track heading from points
// Streams points and attaches to each the heading of an adjacent segment.
// ----------------------------------------------------------------------------
// Each point on the input stream carries an east and a north coordinate
// (degrees times 2^23). The block holds the previous point; when a new one
// arrives it emits the previous point with the heading toward the new one,
// clockwise from north in 1/65536 turn. A point marked with tlast is emitted
// as well, with the heading of the segment before it and tlast set; a lone
// last point gets heading 0, as does a segment of zero length. The first point
// of a track produces nothing on its own. Timing: the front end takes a
// transaction in any cycle in which the two-entry job queue has room. The back
// end takes a job, normalizes it, runs the CORDIC_STEPS steps of the shared
// shift-add CORDIC unit and loads each result into the output register when
// that register is free; a zero-length segment or lone point skips the
// CORDIC. It takes no new job until the last one's results are loaded, so
// that single CORDIC unit sets the sustained rate.
module track_heading_from_points #(
	parameter int COORD_BITS   = thfp_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STEPS = thfp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// east_coord [31:0], north_coord [62:32], zero [63]
	input  logic [thfp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// is_last_point
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// point_east [31:0], point_north [62:32], heading [78:63], zero [79]
	output logic [thfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// track_end
	output logic                                m_axis_tlast
);

	logic                                  push;
	logic                                  pop;
	logic                                  q_full;
	logic                                  q_empty;
	thfp_pkg::job_t                        push_job;
	thfp_pkg::job_t                        q_head;
	logic signed [thfp_pkg::EAST_W-1:0]    in_east;
	logic signed [thfp_pkg::NORTH_W-1:0]   in_north;

	assign in_east  = signed'(s_axis_tdata[thfp_pkg::EAST_W-1:0]);
	assign in_north = signed'(s_axis_tdata[thfp_pkg::EAST_W +: thfp_pkg::NORTH_W]);

	// Front end: holds the previous point and classifies each transaction.
	thfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_east  (in_east),
		.in_north (in_north),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	// Decouples the front end from the CORDIC so either side can stall.
	thfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Back end: CORDIC heading and the output register.
	thfp_back #(
		.COORD_BITS   (COORD_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule
